[rtl/utce_pkg.sv]
// utce_pkg: widths, constants and month table for the utc date to epoch seconds converter
`default_nettype none

package utce_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int SECS_W   = 38;

   // datapath widths of the shared multiplier
   localparam int DAYS_W   = 22;
   localparam int MUL_B_W  = 17;
   localparam int PROD_W   = DAYS_W + MUL_B_W;
   localparam int QY_W     = 7;
   localparam int LEAPS_W  = 12;

   // calendar limits
   localparam int EPOCH_YEAR = 1970;
   localparam int MAX_YEAR   = 9999;

   // leap years in 1 .. EPOCH_YEAR-1
   localparam int LEAPS_BEFORE_EPOCH =
      (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

   // divide by 100 through a reciprocal, exact for values below 2**14
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;

   localparam int DAYS_PER_YEAR = 365;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int CENTURY       = 100;

   // days before the first of each month in a common year
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

[rtl/utc_date_to_epoch_seconds.sv]
// utc_date_to_epoch_seconds: calendar timestamp to seconds since the epoch, one shared multiplier
//
//   channel   ports                         handshake
//   request   req_cal_year .. req_cal_second accepted when start & !busy
//   response  rsp_epoch_seconds, rsp_date_invalid  rsp_valid strobe, one cycle
//
// a valid request is answered after six passes through the one registered multiplier,
// a day total and a final accumulate, each a state of the sequencer.
// an invalid request is answered in the cycle after acceptance.
// busy is high while the sequencer runs; a new request is taken in the cycle of the strobe.
// synchronous reset clears the sequencer and the strobe; the receiver cannot stall.
`default_nettype none

module utc_date_to_epoch_seconds (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [utce_pkg::YEAR_W-1:0]      req_cal_year,
   input  wire logic [utce_pkg::MONTH_W-1:0]     req_cal_month,
   input  wire logic [utce_pkg::DAY_W-1:0]       req_cal_day,
   input  wire logic [utce_pkg::HOUR_W-1:0]      req_cal_hour,
   input  wire logic [utce_pkg::MINUTE_W-1:0]    req_cal_minute,
   input  wire logic [utce_pkg::SECOND_W-1:0]    req_cal_second,
   output logic                                  rsp_valid,
   output logic [utce_pkg::SECS_W-1:0]           rsp_epoch_seconds,
   output logic                                  rsp_date_invalid
);

   typedef enum logic [3:0] {
      IDLE,
      MUL_QY,
      MUL_R,
      MUL_YR,
      SUM_DAYS,
      MUL_DAY,
      MUL_HR,
      MUL_MIN,
      ADD_SEC
   } state_type;

   state_type                            state_ff, state_in;

   logic [utce_pkg::YEAR_W-1:0]          year_ff;
   logic [utce_pkg::MONTH_W-1:0]         month_ff;
   logic [utce_pkg::DAY_W-1:0]           day_ff;
   logic [utce_pkg::HOUR_W-1:0]          hour_ff;
   logic [utce_pkg::MINUTE_W-1:0]        minute_ff;
   logic [utce_pkg::SECOND_W-1:0]        second_ff;

   logic [utce_pkg::PROD_W-1:0]          prod_ff, prod_in;
   logic [utce_pkg::SECS_W-1:0]          acc_ff;
   logic [utce_pkg::DAYS_W-1:0]          days_ff;
   logic [utce_pkg::QY_W-1:0]            qy_ff;
   logic                                 rzero_ff;
   logic                                 leap_ff;

   logic                                 rsp_valid_ff;
   logic [utce_pkg::SECS_W-1:0]          rsp_secs_ff;
   logic                                 rsp_bad_ff;

   logic [utce_pkg::DAYS_W-1:0]          mul_a;
   logic [utce_pkg::MUL_B_W-1:0]         mul_b;
   logic                                 req_bad;
   logic                                 rzero_now;
   logic [utce_pkg::YEAR_W-1:0]          year_m1;
   logic [utce_pkg::QY_W-1:0]            qy_prev;
   logic [utce_pkg::LEAPS_W-1:0]         leaps;
   logic [utce_pkg::DAYS_W-1:0]          days_sum;
   logic [utce_pkg::SECS_W-1:0]          acc_sum;

   // range checks on the incoming request
   always_comb begin
      req_bad = 1'b0;
      if (req_cal_year < utce_pkg::YEAR_W'(utce_pkg::EPOCH_YEAR) ||
          req_cal_year > utce_pkg::YEAR_W'(utce_pkg::MAX_YEAR)) begin
         req_bad = 1'b1;
      end
      if (req_cal_month < 4'd1 || req_cal_month > 4'd12) begin
         req_bad = 1'b1;
      end
      if (req_cal_day == '0) begin
         req_bad = 1'b1;
      end
      if (req_cal_hour > 5'd23) begin
         req_bad = 1'b1;
      end
      if (req_cal_minute > 6'd59) begin
         req_bad = 1'b1;
      end
      if (req_cal_second > 6'd60) begin
         req_bad = 1'b1;
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         MUL_QY: begin
            mul_a = utce_pkg::DAYS_W'(year_ff);
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::DIV100_MUL);
         end
         MUL_R: begin
            mul_a = utce_pkg::DAYS_W'(
               prod_ff[utce_pkg::DIV100_SHIFT +: utce_pkg::QY_W]);
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::CENTURY);
         end
         MUL_YR: begin
            mul_a = utce_pkg::DAYS_W'(year_ff - utce_pkg::YEAR_W'(utce_pkg::EPOCH_YEAR));
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::DAYS_PER_YEAR);
         end
         MUL_DAY: begin
            mul_a = days_ff;
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::SECS_PER_DAY);
         end
         MUL_HR: begin
            mul_a = utce_pkg::DAYS_W'(hour_ff);
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::SECS_PER_HOUR);
         end
         MUL_MIN: begin
            mul_a = utce_pkg::DAYS_W'(minute_ff);
            mul_b = utce_pkg::MUL_B_W'(utce_pkg::SECS_PER_MIN);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = utce_pkg::PROD_W'(mul_a) * utce_pkg::PROD_W'(mul_b);
   end

   // century remainder test, leap count and day total
   always_comb begin
      rzero_now = (year_ff == prod_ff[utce_pkg::YEAR_W-1:0]);
      year_m1   = year_ff - utce_pkg::YEAR_W'(1);
      // floor((year-1)/100) is one less than year/100 exactly on a century
      qy_prev   = qy_ff - utce_pkg::QY_W'(rzero_ff);
      leaps     = utce_pkg::LEAPS_W'(year_m1 >> 2) - utce_pkg::LEAPS_W'(qy_prev)
                + utce_pkg::LEAPS_W'(qy_prev >> 2);
      days_sum  = prod_ff[utce_pkg::DAYS_W-1:0]
                + utce_pkg::DAYS_W'(leaps)
                - utce_pkg::DAYS_W'(utce_pkg::LEAPS_BEFORE_EPOCH)
                + utce_pkg::DAYS_W'(utce_pkg::days_before_month(month_ff))
                + utce_pkg::DAYS_W'((month_ff > 4'd2) && leap_ff)
                + utce_pkg::DAYS_W'(day_ff)
                - utce_pkg::DAYS_W'(1);
      acc_sum   = acc_ff + prod_ff[utce_pkg::SECS_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (start && !req_bad) begin
               state_in = MUL_QY;
            end
         end
         MUL_QY:   state_in = MUL_R;
         MUL_R:    state_in = MUL_YR;
         MUL_YR:   state_in = SUM_DAYS;
         SUM_DAYS: state_in = MUL_DAY;
         MUL_DAY:  state_in = MUL_HR;
         MUL_HR:   state_in = MUL_MIN;
         MUL_MIN:  state_in = ADD_SEC;
         ADD_SEC:  state_in = IDLE;
         default:  state_in = IDLE;
      endcase
   end

   // sequencer, datapath registers and registered response
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rsp_valid_ff <= 1'b0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               year_ff   <= req_cal_year;
               month_ff  <= req_cal_month;
               day_ff    <= req_cal_day;
               hour_ff   <= req_cal_hour;
               minute_ff <= req_cal_minute;
               second_ff <= req_cal_second;
               if (req_bad) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_secs_ff  <= '0;
                  rsp_bad_ff   <= 1'b1;
               end
            end
         end
         MUL_R: begin
            qy_ff <= prod_ff[utce_pkg::DIV100_SHIFT +: utce_pkg::QY_W];
         end
         MUL_YR: begin
            rzero_ff <= rzero_now;
            leap_ff  <= rzero_now ? (qy_ff[1:0] == 2'b00) : (year_ff[1:0] == 2'b00);
         end
         SUM_DAYS: begin
            days_ff <= days_sum;
         end
         MUL_HR: begin
            acc_ff <= prod_ff[utce_pkg::SECS_W-1:0];
         end
         MUL_MIN: begin
            acc_ff <= acc_sum;
         end
         ADD_SEC: begin
            rsp_valid_ff <= 1'b1;
            rsp_secs_ff  <= acc_sum + utce_pkg::SECS_W'(second_ff);
            rsp_bad_ff   <= 1'b0;
         end
         default: begin
         end
      endcase
      state_ff <= state_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign busy              = (state_ff != IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_secs_ff;
   assign rsp_date_invalid  = rsp_bad_ff;

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench for utc_date_to_epoch_seconds: random and directed timestamps checked by a scoreboard
`timescale 1ns / 100ps

module testbench;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int DRAIN_CYCLES   = 16;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int FIRST_YEAR     = 1970;
   localparam longint unsigned DAY_SECS  = 86400;
   localparam longint unsigned HOUR_SECS = 3600;
   localparam longint unsigned MIN_SECS  = 60;
   localparam int unsigned MONTH_OFFSET [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct {
      logic [utce_pkg::SECS_W-1:0] seconds;
      logic                        invalid;
   } epoch_result_type;

   // expected responses, predicted from each accepted request
   class epoch_scoreboard_type;
      epoch_result_type pending_epochs[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      static function bit is_leap_year(longint unsigned y);
         return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
      endfunction

      // leap years in 1 .. y-1
      static function longint unsigned leaps_through(longint unsigned y);
         longint unsigned p;
         p = y - 1;
         return p / 4 - p / 100 + p / 400;
      endfunction

      function epoch_result_type seconds_since_epoch(
         logic [utce_pkg::YEAR_W-1:0] year, logic [utce_pkg::MONTH_W-1:0] month,
         logic [utce_pkg::DAY_W-1:0] day, logic [utce_pkg::HOUR_W-1:0] hour,
         logic [utce_pkg::MINUTE_W-1:0] minute, logic [utce_pkg::SECOND_W-1:0] second);
         epoch_result_type r;
         longint unsigned  y;
         longint unsigned  days;
         longint unsigned  secs;
         r.seconds = '0;
         r.invalid = 1'b1;
         if (year < FIRST_YEAR || year > utce_pkg::MAX_YEAR || month < 1 || month > 12 ||
             day < 1 || hour > 23 || minute > 59 || second > 60)
            return r;
         y = year;
         days = 365 * (y - FIRST_YEAR) + leaps_through(y) - leaps_through(FIRST_YEAR);
         days += MONTH_OFFSET[int'(month) - 1];
         // in a leap year, february has a leap day
         if (month > 2 && is_leap_year(y))
            days += 1;
         days += longint'(day) - 1;
         secs = days * DAY_SECS + hour * HOUR_SECS + minute * MIN_SECS + second;
         r.seconds = secs[utce_pkg::SECS_W-1:0];
         r.invalid = 1'b0;
         return r;
      endfunction

      function void note_request(
         logic [utce_pkg::YEAR_W-1:0] year, logic [utce_pkg::MONTH_W-1:0] month,
         logic [utce_pkg::DAY_W-1:0] day, logic [utce_pkg::HOUR_W-1:0] hour,
         logic [utce_pkg::MINUTE_W-1:0] minute, logic [utce_pkg::SECOND_W-1:0] second);
         pending_epochs.push_back(seconds_since_epoch(year, month, day, hour, minute, second));
      endfunction

      function void check_response(logic [utce_pkg::SECS_W-1:0] seconds, logic invalid);
         epoch_result_type want;
         if (pending_epochs.size() == 0) begin
            $error("response with no request outstanding: epoch_seconds %0d date_invalid %0b",
                   seconds, invalid);
            mismatches++;
            return;
         end
         want = pending_epochs.pop_front();
         if (seconds !== want.seconds) begin
            $error("epoch_seconds mismatch: expected %0d, actual %0d", want.seconds, seconds);
            mismatches++;
         end
         if (invalid !== want.invalid) begin
            $error("date_invalid mismatch: expected %0b, actual %0b", want.invalid, invalid);
            mismatches++;
         end
      endfunction

      function int pending_count();
         return pending_epochs.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [utce_pkg::YEAR_W-1:0]         req_cal_year = '0;
   logic [utce_pkg::MONTH_W-1:0]        req_cal_month = '0;
   logic [utce_pkg::DAY_W-1:0]          req_cal_day = '0;
   logic [utce_pkg::HOUR_W-1:0]         req_cal_hour = '0;
   logic [utce_pkg::MINUTE_W-1:0]       req_cal_minute = '0;
   logic [utce_pkg::SECOND_W-1:0]       req_cal_second = '0;
   logic                                rsp_valid;
   logic [utce_pkg::SECS_W-1:0]         rsp_epoch_seconds;
   logic                                rsp_date_invalid;

   epoch_scoreboard_type board = new();
   int unsigned          cycle_count = 0;
   bit                   burst_mode = 1'b0;

   utc_date_to_epoch_seconds dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cal_year      (req_cal_year),
      .req_cal_month     (req_cal_month),
      .req_cal_day       (req_cal_day),
      .req_cal_hour      (req_cal_hour),
      .req_cal_minute    (req_cal_minute),
      .req_cal_second    (req_cal_second),
      .rsp_valid         (rsp_valid),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_date_invalid  (rsp_date_invalid)
   );

   // clock generation
   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // response check first, then record the request taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            board.check_response(rsp_epoch_seconds, rsp_date_invalid);
         if (start && !busy)
            board.note_request(req_cal_year, req_cal_month, req_cal_day, req_cal_hour,
                               req_cal_minute, req_cal_second);
      end
   end

   // present one request and hold it until the block takes it
   task automatic send_request(int year, int month, int day, int hour, int minute, int second);
      @(negedge clock);
      start          = 1'b1;
      req_cal_year   = year[utce_pkg::YEAR_W-1:0];
      req_cal_month  = month[utce_pkg::MONTH_W-1:0];
      req_cal_day    = day[utce_pkg::DAY_W-1:0];
      req_cal_hour   = hour[utce_pkg::HOUR_W-1:0];
      req_cal_minute = minute[utce_pkg::MINUTE_W-1:0];
      req_cal_second = second[utce_pkg::SECOND_W-1:0];
      do @(posedge clock); while (busy);
   endtask

   task automatic idle_for(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic wait_for_responses();
      while (board.pending_count() > 0)
         @(posedge clock);
   endtask

   // well-formed timestamp with random content, sometimes with one field broken or every field over its full width
   task automatic send_random_request();
      int year, month, day, hour, minute, second, r;
      r = $urandom_range(0, 99);
      if (r < 10)
         year = $urandom_range(FIRST_YEAR, 2100);
      else if (r < 25)
         year = $urandom_range(20, 99) * 100 - $urandom_range(0, 1);
      else
         year = $urandom_range(FIRST_YEAR, utce_pkg::MAX_YEAR);
      month  = $urandom_range(1, 12);
      day    = ($urandom_range(0, 3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
      hour   = $urandom_range(0, 23);
      minute = $urandom_range(0, 59);
      second = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 59);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // every field over its full width
         year   = $urandom_range(0, (1 << utce_pkg::YEAR_W) - 1);
         month  = $urandom_range(0, (1 << utce_pkg::MONTH_W) - 1);
         day    = $urandom_range(0, (1 << utce_pkg::DAY_W) - 1);
         hour   = $urandom_range(0, (1 << utce_pkg::HOUR_W) - 1);
         minute = $urandom_range(0, (1 << utce_pkg::MINUTE_W) - 1);
         second = $urandom_range(0, (1 << utce_pkg::SECOND_W) - 1);
      end else if (r < 20) begin
         // one field out of range
         case ($urandom_range(0, 5))
            0: year = ($urandom_range(0, 1) == 0) ? $urandom_range(0, FIRST_YEAR - 1)
                                                  : $urandom_range(utce_pkg::MAX_YEAR + 1,
                                                                   16383);
            1: month = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
            2: day = 0;
            3: hour = $urandom_range(24, 31);
            4: minute = $urandom_range(60, 63);
            default: second = $urandom_range(61, 63);
         endcase
      end
      send_request(year, month, day, hour, minute, second);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: epoch start, extremes, leap rules, leap second, invalid fields
      send_request(1970, 1, 1, 0, 0, 0);
      send_request(9999, 12, 31, 23, 59, 60);
      send_request(9999, 15, 31, 31, 63, 63);
      send_request(0, 0, 0, 0, 0, 0);
      send_request(1969, 12, 31, 23, 59, 59);
      send_request(10000, 1, 1, 0, 0, 0);
      send_request(16383, 15, 31, 31, 63, 63);
      send_request(2000, 0, 1, 0, 0, 0);
      send_request(2000, 13, 1, 0, 0, 0);
      send_request(2000, 1, 0, 0, 0, 0);
      send_request(2000, 1, 1, 24, 0, 0);
      send_request(2000, 1, 1, 0, 60, 0);
      send_request(2000, 1, 1, 0, 0, 61);
      send_request(2016, 12, 31, 23, 59, 60);
      send_request(2000, 2, 29, 12, 0, 0);
      send_request(2000, 3, 1, 0, 0, 0);
      send_request(2100, 3, 1, 0, 0, 0);
      send_request(2400, 3, 1, 0, 0, 0);
      send_request(2001, 2, 31, 0, 0, 0);
      send_request(2004, 2, 31, 0, 0, 0);
      send_request(2038, 1, 19, 3, 14, 8);
      send_request(1972, 12, 31, 23, 59, 59);
      send_request(8191, 4, 30, 16, 32, 31);
      idle_for(3);

      // random requests with bursts and gaps
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS / 2) begin
            idle_for(1);
            wait_for_responses();
         end
         send_random_request();
         idle_for(gap_length());
      end

      // drain
      @(negedge clock);
      start = 1'b0;
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_count() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

[utc_date_to_epoch_seconds.f]
rtl/utce_pkg.sv
rtl/utc_date_to_epoch_seconds.sv
verif/testbench.sv
